// ----- src/tcc_pkg.sv -----
package tcc_pkg;

   localparam int CoordW    = 24;
   localparam int DiffW     = CoordW + 1;
   localparam int SqW       = 2 * CoordW;
   localparam int PW        = 2 * DiffW;
   localparam int SW        = 2 * CoordW + 1;
   localparam int CW        = 2 * CoordW + 4;
   localparam int NW        = 3 * CoordW + 2;
   localparam int EW        = NW + 2;
   localparam int DigitW    = 16;
   localparam int MulDigits = 5;
   localparam int MulW      = DigitW * MulDigits;
   localparam int ProdW     = 2 * MulW;
   localparam int MulLat    = MulDigits + 1;
   localparam int QW        = CoordW;
   localparam int DivW      = CW;
   localparam int RootW     = 2 * EW;
   localparam int PipeLat   = 2 * MulLat + 4 + QW;

   localparam logic [1:0] StatusOk         = 2'd0;
   localparam logic [1:0] StatusDegenerate = 2'd1;
   localparam logic [1:0] StatusSaturated  = 2'd2;

   typedef struct packed {
      logic signed [CoordW-1:0] vertex0_x;
      logic signed [CoordW-1:0] vertex0_y;
      logic signed [CoordW-1:0] vertex1_x;
      logic signed [CoordW-1:0] vertex1_y;
      logic signed [CoordW-1:0] vertex2_x;
      logic signed [CoordW-1:0] vertex2_y;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic        [CoordW-1:0] radius;
      logic        [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic signed [MulW-1:0] a;
      logic        [MulW-1:0] b;
      logic signed [MulW+1:0] hi;
      logic        [MulW-1:0] lo;
      logic                   neg;
   } mul_cell_type;

   typedef struct packed {
      logic [DivW-1:0] dvs;
      logic [DivW-1:0] rem;
      logic [QW-1:0]   num;
      logic [QW-1:0]   quo;
   } div_cell_type;

   typedef struct packed {
      logic [RootW-1:0] rest;
      logic [RootW-1:0] acc;
      logic [RootW-1:0] step;
      logic [QW-1:0]    root;
   } root_cell_type;

   typedef struct packed {
      logic zero;
      logic sat_r;
      logic ovf_x;
      logic ovf_y;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

// ----- src/tcc_mul_cell.sv -----
module tcc_mul_cell (
   input  logic                  clock,
   input  logic                  en,
   input  tcc_pkg::mul_cell_type cell_in,
   output tcc_pkg::mul_cell_type cell_out
);
   import tcc_pkg::*;

   logic signed [MulW+DigitW:0]   part;
   logic signed [MulW+DigitW+1:0] sum;
   mul_cell_type                  cell_ff;

   assign part = cell_in.a * $signed({1'b0, cell_in.b[DigitW-1:0]});
   assign sum  = {{DigitW{cell_in.hi[MulW+1]}}, cell_in.hi} + {part[MulW+DigitW], part};

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff.a   <= cell_in.a;
         cell_ff.neg <= cell_in.neg;
         cell_ff.b   <= {{DigitW{1'b0}}, cell_in.b[MulW-1:DigitW]};
         cell_ff.hi  <= sum[MulW+DigitW+1:DigitW];
         cell_ff.lo  <= {sum[DigitW-1:0], cell_in.lo[MulW-1:DigitW]};
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- src/tcc_mul.sv -----
module tcc_mul (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [tcc_pkg::MulW-1:0]    a_in,
   input  logic signed [tcc_pkg::MulW-1:0]    b_in,
   output logic signed [tcc_pkg::ProdW-1:0]   prod
);
   import tcc_pkg::*;

   mul_cell_type            chain [MulDigits+1];
   logic        [MulW-1:0]  top_in;
   logic signed [ProdW-1:0] prod_ff;

   assign chain[0] = '{a: a_in, b: b_in, hi: '0, lo: '0, neg: b_in[MulW-1]};

   for (genvar i = 0; i < MulDigits; i++) begin : g_cell
      tcc_mul_cell u_cell (
         .clock    (clock),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // The digits of b are taken as unsigned, so a negative b is corrected here.
   assign top_in = chain[MulDigits].hi[MulW-1:0]
                 - (chain[MulDigits].neg ? chain[MulDigits].a : '0);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {top_in, chain[MulDigits].lo};
      end
   end

   assign prod = prod_ff;

endmodule

// ----- src/tcc_div_cell.sv -----
module tcc_div_cell (
   input  logic                  clock,
   input  logic                  en,
   input  tcc_pkg::div_cell_type cell_in,
   output tcc_pkg::div_cell_type cell_out
);
   import tcc_pkg::*;

   logic [DivW:0] cand;
   logic [DivW:0] diff;
   logic          take;
   div_cell_type  cell_ff;

   assign cand = {cell_in.rem, cell_in.num[QW-1]};
   assign diff = cand - {1'b0, cell_in.dvs};
   assign take = cand >= {1'b0, cell_in.dvs};

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff.dvs <= cell_in.dvs;
         cell_ff.rem <= take ? diff[DivW-1:0] : cand[DivW-1:0];
         cell_ff.num <= {cell_in.num[QW-2:0], 1'b0};
         cell_ff.quo <= {cell_in.quo[QW-2:0], take};
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- src/tcc_root_cell.sv -----
module tcc_root_cell (
   input  logic                   clock,
   input  logic                   en,
   input  tcc_pkg::root_cell_type cell_in,
   output tcc_pkg::root_cell_type cell_out
);
   import tcc_pkg::*;

   logic [RootW:0]   trial;
   logic [RootW-1:0] acc_next;
   logic             take;
   root_cell_type    cell_ff;

   // The trial is the growth of root squared times the divisor when this bit is set.
   assign trial    = {1'b0, cell_in.acc} + {1'b0, cell_in.step};
   assign take     = trial <= {1'b0, cell_in.rest};
   assign acc_next = take ? cell_in.acc + {cell_in.step[RootW-2:0], 1'b0} : cell_in.acc;

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff.rest <= take ? cell_in.rest - trial[RootW-1:0] : cell_in.rest;
         cell_ff.acc  <= {1'b0, acc_next[RootW-1:1]};
         cell_ff.step <= {2'b00, cell_in.step[RootW-1:2]};
         cell_ff.root <= {cell_in.root[QW-2:0], take};
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- src/triangle_circumcircle_unit.sv -----
// Circumscribed circle of a triangle given by three signed Q16.8 vertices: the centre is
// returned in signed Q16.8, rounded toward zero, and the radius in unsigned Q16.8, floored.
// Collinear vertices give status degenerate with zero outputs, and a value out of range is
// saturated with status saturated. One transaction is accepted every clock cycle while the
// output is not stalled. The pipeline passes through two multiplier chains in sequence and
// the 24 cells of the dividers and the square-root chain, one result bit per cell.
// The whole pipeline holds while a result is stalled at the output.
module triangle_circumcircle_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcc_pkg::rsp_type rsp_data
);
   import tcc_pkg::*;

   function automatic logic [CoordW:0] clamp_coord(input logic [QW-1:0] q,
                                                   input logic neg, input logic ovf);
      logic [CoordW-1:0] cmax;
      logic [CoordW-1:0] cmin;
      logic              sat;
      logic [CoordW-1:0] val;
      cmax = {1'b0, {(CoordW-1){1'b1}}};
      cmin = {1'b1, {(CoordW-1){1'b0}}};
      if (neg) begin
         sat = ovf || (q > cmin);
         val = sat ? cmin : -q;
      end else begin
         sat = ovf || q[QW-1];
         val = sat ? cmax : q;
      end
      return {sat, val};
   endfunction

   logic               en;
   logic [PipeLat-1:0] vld_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_in;

   logic signed [DiffW-1:0]  dx1_in, dy1_in, dx2_in, dy2_in;
   logic signed [PW-1:0]     p1_in, p2_in;
   logic signed [SqW-1:0]    sqx0_in, sqy0_in, sqx1_in, sqy1_in, sqx2_in, sqy2_in;
   logic signed [DiffW-1:0]  dx1_a_ff, dy1_a_ff, dx2_a_ff, dy2_a_ff;
   logic signed [PW-1:0]     p1_a_ff, p2_a_ff;
   logic signed [SqW-1:0]    sqx0_a_ff, sqy0_a_ff, sqx1_a_ff, sqy1_a_ff, sqx2_a_ff, sqy2_a_ff;
   logic signed [CoordW-1:0] x0_a_ff, y0_a_ff;

   logic signed [DiffW-1:0]  dx1_b_ff, dy1_b_ff, dx2_b_ff, dy2_b_ff;
   logic signed [SW-1:0]     s1_b_ff, s2_b_ff;
   logic signed [CW-1:0]     c_b_ff;
   logic signed [CoordW-1:0] x0_b_ff, y0_b_ff;

   logic signed [ProdW-1:0]  m0, m1, m2, m3, m4, m5;
   logic signed [CW-1:0]     c_m1_ff [MulLat];

   logic [EW-1:0]            nxw, nyw, exw, eyw;
   logic signed [NW-1:0]     nx_d_ff, ny_d_ff;
   logic signed [EW-1:0]     ex_d_ff, ey_d_ff;
   logic signed [CW-1:0]     c_d_ff;

   logic signed [ProdW-1:0]  pxx, pyy, pcc;
   logic signed [NW-1:0]     nx_m2_ff [MulLat];
   logic signed [NW-1:0]     ny_m2_ff [MulLat];
   logic signed [CW-1:0]     c_m2_ff  [MulLat];

   logic signed [NW-1:0]     nx_f, ny_f;
   logic signed [CW-1:0]     c_f;
   logic [NW-1:0]            abs_nx, abs_ny;
   logic [DivW-1:0]          abs_c;
   logic [RootW-1:0]         e_sum, c_sq;
   side_type                 side_in;
   side_type                 side_ff [QW+1];

   div_cell_type             divx_chain [QW+1];
   div_cell_type             divy_chain [QW+1];
   root_cell_type            root_chain [QW+1];
   div_cell_type             divx_f_ff, divy_f_ff;
   root_cell_type            root_f_ff;

   side_type                 side_o;
   logic [CoordW:0]          cx_o, cy_o;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PipeLat-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PipeLat-1];
      end
   end

   // Differences to the first vertex, squares and the cross products.
   assign dx1_in  = DiffW'(req_data.vertex1_x) - DiffW'(req_data.vertex0_x);
   assign dy1_in  = DiffW'(req_data.vertex1_y) - DiffW'(req_data.vertex0_y);
   assign dx2_in  = DiffW'(req_data.vertex2_x) - DiffW'(req_data.vertex0_x);
   assign dy2_in  = DiffW'(req_data.vertex2_y) - DiffW'(req_data.vertex0_y);
   assign p1_in   = dx1_in * dy2_in;
   assign p2_in   = dy1_in * dx2_in;
   assign sqx0_in = req_data.vertex0_x * req_data.vertex0_x;
   assign sqy0_in = req_data.vertex0_y * req_data.vertex0_y;
   assign sqx1_in = req_data.vertex1_x * req_data.vertex1_x;
   assign sqy1_in = req_data.vertex1_y * req_data.vertex1_y;
   assign sqx2_in = req_data.vertex2_x * req_data.vertex2_x;
   assign sqy2_in = req_data.vertex2_y * req_data.vertex2_y;

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_a_ff  <= dx1_in;
         dy1_a_ff  <= dy1_in;
         dx2_a_ff  <= dx2_in;
         dy2_a_ff  <= dy2_in;
         p1_a_ff   <= p1_in;
         p2_a_ff   <= p2_in;
         sqx0_a_ff <= sqx0_in;
         sqy0_a_ff <= sqy0_in;
         sqx1_a_ff <= sqx1_in;
         sqy1_a_ff <= sqy1_in;
         sqx2_a_ff <= sqx2_in;
         sqy2_a_ff <= sqy2_in;
         x0_a_ff   <= req_data.vertex0_x;
         y0_a_ff   <= req_data.vertex0_y;

         dx1_b_ff  <= dx1_a_ff;
         dy1_b_ff  <= dy1_a_ff;
         dx2_b_ff  <= dx2_a_ff;
         dy2_b_ff  <= dy2_a_ff;
         s1_b_ff   <= SW'(sqx1_a_ff) + SW'(sqy1_a_ff) - SW'(sqx0_a_ff) - SW'(sqy0_a_ff);
         s2_b_ff   <= SW'(sqx2_a_ff) + SW'(sqy2_a_ff) - SW'(sqx0_a_ff) - SW'(sqy0_a_ff);
         c_b_ff    <= (CW'(p1_a_ff) - CW'(p2_a_ff)) <<< 1;
         x0_b_ff   <= x0_a_ff;
         y0_b_ff   <= y0_a_ff;
      end
   end

   tcc_mul u_mul_m0 (.clock(clock), .en(en), .a_in(MulW'(dy2_b_ff)), .b_in(MulW'(s1_b_ff)),
                     .prod(m0));
   tcc_mul u_mul_m1 (.clock(clock), .en(en), .a_in(MulW'(dy1_b_ff)), .b_in(MulW'(s2_b_ff)),
                     .prod(m1));
   tcc_mul u_mul_m2 (.clock(clock), .en(en), .a_in(MulW'(dx2_b_ff)), .b_in(MulW'(s1_b_ff)),
                     .prod(m2));
   tcc_mul u_mul_m3 (.clock(clock), .en(en), .a_in(MulW'(dx1_b_ff)), .b_in(MulW'(s2_b_ff)),
                     .prod(m3));
   tcc_mul u_mul_m4 (.clock(clock), .en(en), .a_in(MulW'(x0_b_ff)), .b_in(MulW'(c_b_ff)),
                     .prod(m4));
   tcc_mul u_mul_m5 (.clock(clock), .en(en), .a_in(MulW'(y0_b_ff)), .b_in(MulW'(c_b_ff)),
                     .prod(m5));

   // Centre numerators, and the same numerators taken relative to the first vertex.
   assign nxw = m0[EW-1:0] - m1[EW-1:0];
   assign nyw = m3[EW-1:0] - m2[EW-1:0];
   assign exw = nxw - m4[EW-1:0];
   assign eyw = nyw - m5[EW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         c_m1_ff[0] <= c_b_ff;
         for (int i = 1; i < MulLat; i++) begin
            c_m1_ff[i] <= c_m1_ff[i-1];
         end
         nx_d_ff <= nxw[NW-1:0];
         ny_d_ff <= nyw[NW-1:0];
         ex_d_ff <= exw;
         ey_d_ff <= eyw;
         c_d_ff  <= c_m1_ff[MulLat-1];
         nx_m2_ff[0] <= nx_d_ff;
         ny_m2_ff[0] <= ny_d_ff;
         c_m2_ff[0]  <= c_d_ff;
         for (int i = 1; i < MulLat; i++) begin
            nx_m2_ff[i] <= nx_m2_ff[i-1];
            ny_m2_ff[i] <= ny_m2_ff[i-1];
            c_m2_ff[i]  <= c_m2_ff[i-1];
         end
      end
   end

   tcc_mul u_mul_xx (.clock(clock), .en(en), .a_in(MulW'(ex_d_ff)), .b_in(MulW'(ex_d_ff)),
                     .prod(pxx));
   tcc_mul u_mul_yy (.clock(clock), .en(en), .a_in(MulW'(ey_d_ff)), .b_in(MulW'(ey_d_ff)),
                     .prod(pyy));
   tcc_mul u_mul_cc (.clock(clock), .en(en), .a_in(MulW'(c_d_ff)), .b_in(MulW'(c_d_ff)),
                     .prod(pcc));

   assign nx_f   = nx_m2_ff[MulLat-1];
   assign ny_f   = ny_m2_ff[MulLat-1];
   assign c_f    = c_m2_ff[MulLat-1];
   assign abs_nx = nx_f[NW-1] ? NW'(-nx_f) : NW'(nx_f);
   assign abs_ny = ny_f[NW-1] ? NW'(-ny_f) : NW'(ny_f);
   assign abs_c  = c_f[CW-1] ? DivW'(-c_f) : DivW'(c_f);
   assign e_sum  = pxx[RootW-1:0] + pyy[RootW-1:0];
   assign c_sq   = pcc[RootW-1:0];

   assign side_in.zero  = (c_f == '0);
   assign side_in.sat_r = e_sum >= (c_sq << (2 * QW));
   assign side_in.ovf_x = EW'(abs_nx) >= (EW'(abs_c) << QW);
   assign side_in.ovf_y = EW'(abs_ny) >= (EW'(abs_c) << QW);
   assign side_in.neg_x = nx_f[NW-1] ^ c_f[CW-1];
   assign side_in.neg_y = ny_f[NW-1] ^ c_f[CW-1];

   always_ff @(posedge clock) begin
      if (en) begin
         divx_f_ff.dvs  <= abs_c;
         divx_f_ff.rem  <= DivW'(abs_nx >> QW);
         divx_f_ff.num  <= abs_nx[QW-1:0];
         divx_f_ff.quo  <= '0;
         divy_f_ff.dvs  <= abs_c;
         divy_f_ff.rem  <= DivW'(abs_ny >> QW);
         divy_f_ff.num  <= abs_ny[QW-1:0];
         divy_f_ff.quo  <= '0;
         root_f_ff.rest <= e_sum;
         root_f_ff.acc  <= '0;
         root_f_ff.step <= c_sq << (2 * QW - 2);
         root_f_ff.root <= '0;
         side_ff[0]     <= side_in;
         for (int i = 1; i <= QW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign divx_chain[0] = divx_f_ff;
   assign divy_chain[0] = divy_f_ff;
   assign root_chain[0] = root_f_ff;

   for (genvar i = 0; i < QW; i++) begin : g_chain
      tcc_div_cell u_divx (
         .clock    (clock),
         .en       (en),
         .cell_in  (divx_chain[i]),
         .cell_out (divx_chain[i+1])
      );
      tcc_div_cell u_divy (
         .clock    (clock),
         .en       (en),
         .cell_in  (divy_chain[i]),
         .cell_out (divy_chain[i+1])
      );
      tcc_root_cell u_root (
         .clock    (clock),
         .en       (en),
         .cell_in  (root_chain[i]),
         .cell_out (root_chain[i+1])
      );
   end

   assign side_o = side_ff[QW];
   assign cx_o   = clamp_coord(divx_chain[QW].quo, side_o.neg_x, side_o.ovf_x);
   assign cy_o   = clamp_coord(divy_chain[QW].quo, side_o.neg_y, side_o.ovf_y);

   always_comb begin
      if (side_o.zero) begin
         rsp_in.center_x = '0;
         rsp_in.center_y = '0;
         rsp_in.radius   = '0;
         rsp_in.status   = StatusDegenerate;
      end else begin
         rsp_in.center_x = cx_o[CoordW-1:0];
         rsp_in.center_y = cy_o[CoordW-1:0];
         rsp_in.radius   = side_o.sat_r ? {CoordW{1'b1}} : root_chain[QW].root;
         rsp_in.status   = (cx_o[CoordW] || cy_o[CoordW] || side_o.sat_r) ?
                           StatusSaturated : StatusOk;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
